[hdl/assert_macros.svh]
// assertion helpers, clocked on clk with asynchronous reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[hdl/ucm_pkg.sv]
// ----------------------------------------------------------------------------
// ucm_pkg
// shared constants and types of the upgma cluster merge block
// ----------------------------------------------------------------------------
package ucm_pkg;
	localparam int MAX_SEQ = 32;
	localparam int IDX_W   = $clog2(MAX_SEQ);
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int DIST_W  = 16;
	localparam int SUM_W   = 27;
	localparam int OSUM_W  = 26;
	localparam int CNT_W   = 9;
	localparam int ID_W    = 6;
	localparam int SIZE_W  = 6;
	localparam int PROD_W  = SUM_W + CNT_W;

	typedef logic [IDX_W-1:0] slot_t;
	typedef logic [SUM_W-1:0] sum_t;

	typedef enum logic [7:0] {
		ST_LOAD = 8'b0000_0001,
		ST_RD   = 8'b0000_0010,
		ST_MUL  = 8'b0000_0100,
		ST_CMP  = 8'b0000_1000,
		ST_EMIT = 8'b0001_0000,
		ST_URD  = 8'b0010_0000,
		ST_UWR  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;
endpackage

[hdl/ucm_sum_ram.sv]
// ----------------------------------------------------------------------------
// ucm_sum_ram
// pair sum store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module ucm_sum_ram #(
	parameter int ADDR_BITS = 10,
	parameter int DATA_BITS = 27
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0] raddr_a,
	input  logic [ADDR_BITS-1:0] raddr_b,
	output logic [DATA_BITS-1:0] rdata_a,
	output logic [DATA_BITS-1:0] rdata_b
);
	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

[hdl/upgma_cluster_merge.sv]
// n*n input items load the matrix, one per cycle unless in_stall; the last one starts merging
// merging: each scanned pair of a merge step passes store read, multiply and compare,
// then an emit state, a sum update through the two-read store and a list update
// input stalls while merging and while cfg_valid is high; each record waits in the output register
// reset clears control state; the sum store holds whatever it held until loaded
// ----------------------------------------------------------------------------
// upgma_cluster_merge
// average linkage clustering over a loaded distance matrix, one record per merge
// ----------------------------------------------------------------------------
module upgma_cluster_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [5:0]                  sequence_count,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ucm_pkg::DIST_W-1:0]  distance,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ucm_pkg::ID_W-1:0]    first_cluster,
	output logic [ucm_pkg::ID_W-1:0]    second_cluster,
	output logic [ucm_pkg::ID_W-1:0]    merged_cluster,
	output logic [ucm_pkg::OSUM_W-1:0]  distance_sum,
	output logic [ucm_pkg::CNT_W-1:0]   pair_count,
	output logic                        last_merge
);
	import ucm_pkg::*;
	`include "assert_macros.svh"

	state_t state_q;
	logic [5:0] seq_q;
	logic [5:0] n;
	slot_t row_q, col_q, i_q, j_q, bi_q, bj_q, sx_q, sy_q;
	logic [5:0] ac_q, m_q, wc_q;
	logic phase_q, have_q;
	slot_t list_q [MAX_SEQ];
	slot_t list_nx [MAX_SEQ];
	logic [SIZE_W-1:0] size_q [MAX_SEQ];
	logic [ID_W-1:0] id_q [MAX_SEQ];
	sum_t bsum_q, s_s2;
	logic [CNT_W-1:0] bcnt_q, c_s1, c_s2;
	logic [PROD_W-1:0] pnew_s2, pbest_s2;
	logic [2*SIZE_W-1:0] cprod;
	logic [ADDR_W-1:0] wa_q, waddr, ra, rb;
	logic we;
	sum_t wdata, rd_a, rd_b;
	slot_t w5;
	logic in_acc, out_load;
	logic scan_st;

	assign n = (seq_q < 6'd2) ? 6'd2 : ((seq_q > 6'(MAX_SEQ)) ? 6'(MAX_SEQ) : seq_q);
	assign cfg_ready = (state_q == ST_LOAD);
	assign in_stall = (state_q != ST_LOAD) || cfg_valid;
	assign in_acc = in_valid && !in_stall;
	assign out_load = (state_q == ST_EMIT) && (!out_valid || !out_stall);
	assign w5 = wc_q[IDX_W-1:0];
	assign cprod = size_q[list_q[i_q]] * size_q[list_q[j_q]];
	assign scan_st = (state_q == ST_RD) || (state_q == ST_MUL) || (state_q == ST_CMP);

	always_comb begin
		we = 1'b0;
		waddr = {row_q, col_q};
		wdata = SUM_W'(distance);
		ra = {list_q[i_q], list_q[j_q]};
		rb = {sy_q, w5};
		if (state_q == ST_LOAD) begin
			we = in_acc;
		end else if (state_q == ST_UWR) begin
			we = 1'b1;
			waddr = wa_q;
			wdata = rd_a + rd_b;
		end
		if (state_q == ST_URD) begin
			if (!phase_q) begin
				ra = {sx_q, w5};
				rb = {sy_q, w5};
			end else begin
				ra = {w5, sx_q};
				rb = {w5, sy_q};
			end
		end
	end

	ucm_sum_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(SUM_W)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .raddr_b(rb), .rdata_a(rd_a), .rdata_b(rd_b)
	);

	always_comb begin
		logic [6:0] src;
		for (int k = 0; k < MAX_SEQ; k++) begin
			if (7'(k) < {2'b0, bj_q}) begin
				src = 7'(k);
			end else if (7'(k) + 7'd1 < {2'b0, bi_q}) begin
				src = 7'(k) + 7'd1;
			end else begin
				src = 7'(k) + 7'd2;
			end
			list_nx[k] = (src < 7'(MAX_SEQ)) ? list_q[src[IDX_W-1:0]] : list_q[k];
		end
		list_nx[IDX_W'(ac_q - 6'd2)] = sx_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		c_s1 <= cprod[CNT_W-1:0];
		if (state_q == ST_MUL) begin
			pnew_s2 <= rd_a * bcnt_q;
			pbest_s2 <= bsum_q * c_s1;
			s_s2 <= rd_a;
			c_s2 <= c_s1;
		end
		if (state_q == ST_URD) begin
			wa_q <= ra;
		end
		if (out_load) begin
			first_cluster <= id_q[list_q[bi_q]];
			second_cluster <= id_q[list_q[bj_q]];
			merged_cluster <= n + m_q;
			distance_sum <= bsum_q[OSUM_W-1:0];
			pair_count <= bcnt_q;
			last_merge <= (ac_q == 6'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			seq_q <= 6'(MAX_SEQ);
			row_q <= '0;
			col_q <= '0;
			ac_q <= '0;
			m_q <= '0;
			i_q <= '0;
			j_q <= '0;
			bi_q <= '0;
			bj_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			wc_q <= '0;
			phase_q <= 1'b0;
			have_q <= 1'b0;
			bsum_q <= '0;
			bcnt_q <= '0;
			out_valid <= 1'b0;
			for (int k = 0; k < MAX_SEQ; k++) begin
				list_q[k] <= '0;
				size_q[k] <= '0;
				id_q[k] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (cfg_valid) begin
						seq_q <= sequence_count;
						row_q <= '0;
						col_q <= '0;
					end else if (in_acc) begin
						if (col_q == IDX_W'(n - 6'd1)) begin
							col_q <= '0;
							if (row_q == IDX_W'(n - 6'd1)) begin
								row_q <= '0;
								for (int k = 0; k < MAX_SEQ; k++) begin
									list_q[k] <= IDX_W'(k);
									size_q[k] <= SIZE_W'(1);
									id_q[k] <= ID_W'(k);
								end
								ac_q <= n;
								m_q <= '0;
								i_q <= IDX_W'(n - 6'd1);
								j_q <= '0;
								have_q <= 1'b0;
								state_q <= ST_RD;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_RD: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_CMP;
				ST_CMP: begin
					if (!have_q || pnew_s2 < pbest_s2) begin
						have_q <= 1'b1;
						bsum_q <= s_s2;
						bcnt_q <= c_s2;
						bi_q <= i_q;
						bj_q <= j_q;
					end
					if (j_q + 1'b1 < i_q) begin
						j_q <= j_q + 1'b1;
						state_q <= ST_RD;
					end else if (i_q > IDX_W'(1)) begin
						i_q <= i_q - 1'b1;
						j_q <= '0;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						sx_q <= list_q[bi_q];
						sy_q <= list_q[bj_q];
						wc_q <= '0;
						phase_q <= 1'b0;
						state_q <= ST_URD;
					end
				end
				ST_URD: begin
					if (wc_q == 6'(MAX_SEQ)) begin
						state_q <= ST_FIN;
					end else if (w5 == sx_q || w5 == sy_q) begin
						wc_q <= wc_q + 1'b1;
						phase_q <= 1'b0;
					end else begin
						state_q <= ST_UWR;
					end
				end
				ST_UWR: begin
					if (phase_q) begin
						phase_q <= 1'b0;
						wc_q <= wc_q + 1'b1;
					end else begin
						phase_q <= 1'b1;
					end
					state_q <= ST_URD;
				end
				ST_FIN: begin
					size_q[sx_q] <= size_q[sx_q] + size_q[sy_q];
					id_q[sx_q] <= n + m_q;
					for (int k = 0; k < MAX_SEQ; k++) begin
						list_q[k] <= list_nx[k];
					end
					ac_q <= ac_q - 6'd1;
					m_q <= m_q + 6'd1;
					i_q <= IDX_W'(ac_q - 6'd2);
					j_q <= '0;
					have_q <= 1'b0;
					state_q <= (ac_q == 6'd2) ? ST_LOAD : ST_RD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`ASSERT_IMPL(a_active_two, state_q != ST_LOAD, ac_q >= 6'd2, "merging with under two clusters")
	`ASSERT_IMPL(a_scan_pair, scan_st, j_q < i_q, "partner not before position")
	`ASSERT_NEXT(a_emit_src, state_q != ST_EMIT && !out_valid, !out_valid, "record without merge")
endmodule
